### sv/rrcs_pkg.sv
// Shared types, constants and byte classifier for the repeat-count screen.
// No dependencies; every other file but rrcs_checker imports this package.
package rrcs_pkg;

    localparam int unsigned CountWidth = 31;
    localparam int unsigned ByteWidth  = 8;
    localparam logic [CountWidth-1:0] ThresholdReset = CountWidth'(50);

    localparam logic [ByteWidth-1:0] ChOpen  = 8'h7B;
    localparam logic [ByteWidth-1:0] ChClose = 8'h7D;
    localparam logic [ByteWidth-1:0] ChComma = 8'h2C;
    localparam logic [ByteWidth-1:0] ChZero  = 8'h30;
    localparam logic [ByteWidth-1:0] ChNine  = 8'h39;

    typedef enum logic [2:0] {
        CLS_OTHER = 3'd0,
        CLS_DIGIT = 3'd1,
        CLS_SPACE = 3'd2,
        CLS_COMMA = 3'd3,
        CLS_CLOSE = 3'd4,
        CLS_OPEN  = 3'd5
    } t_cls;

    typedef struct packed {
        t_cls       cls;
        logic [3:0] digit;
        logic       last;
    } t_item;

    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_OPEN   = 7'b0000010,
        PH_NUM1   = 7'b0000100,
        PH_AFTER1 = 7'b0001000,
        PH_COMMA  = 7'b0010000,
        PH_NUM2   = 7'b0100000,
        PH_AFTER2 = 7'b1000000
    } t_phase;

    function automatic t_cls classify(input logic [ByteWidth-1:0] c);
        t_cls k;
        k = CLS_OTHER;
        if (c == ChOpen) begin
            k = CLS_OPEN;
        end else if (c == ChClose) begin
            k = CLS_CLOSE;
        end else if (c == ChComma) begin
            k = CLS_COMMA;
        end else if (c >= ChZero && c <= ChNine) begin
            k = CLS_DIGIT;
        end else if (c == 8'h09 || c == 8'h0A || c == 8'h0C || c == 8'h0D || c == 8'h20) begin
            k = CLS_SPACE;
        end
        return k;
    endfunction

endpackage

### sv/rrcs_front.sv
// Front end: classifies each incoming byte into a compact token.
// Depends on rrcs_pkg.
module rrcs_front import rrcs_pkg::*; (
    input  logic [ByteWidth-1:0] i_byte,
    input  logic                 i_last,
    output t_item                o_item
);

    logic [ByteWidth-1:0] w_digit;

    assign w_digit = i_byte - ChZero;

    always_comb begin
        o_item.cls   = classify(i_byte);
        o_item.digit = w_digit[3:0];
        o_item.last  = i_last;
    end

endmodule

### sv/rrcs_queue.sv
// Two-entry token queue between front and back end.
// Depends on rrcs_pkg.
module rrcs_queue import rrcs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_fill;

    assign o_full  = r_fill[1];
    assign o_valid = (r_fill != 2'd0);
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_fill <= r_fill + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

### sv/rrcs_back.sv
// Back end: quantifier state machine, count accumulator and result register.
// Depends on rrcs_pkg.
module rrcs_back import rrcs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [CountWidth-1:0] i_threshold,
    input  logic                  i_valid,
    input  t_item                 i_item,
    output logic                  o_pop,
    output logic                  o_res_valid,
    output logic                  o_res_flag,
    input  logic                  i_res_ready
);

    t_phase                r_ph,  n_ph;
    logic [CountWidth-1:0] r_cnt, n_cnt;
    logic                  r_sat, n_sat;
    logic                  r_first, n_first;
    logic                  r_found, n_found;
    logic                  r_out_valid;
    logic                  r_out_flag;

    logic [CountWidth+3:0] w_acc;
    logic                  w_acc_sat;
    logic                  w_large;
    logic                  w_digit_first_large;

    assign o_pop       = i_valid && (!i_item.last || !r_out_valid || i_res_ready);
    assign o_res_valid = r_out_valid;
    assign o_res_flag  = r_out_flag;

    // count * 10 + digit
    assign w_acc = ({4'd0, r_cnt} << 3) + ({4'd0, r_cnt} << 1)
                 + {{(CountWidth){1'b0}}, i_item.digit};
    assign w_acc_sat = r_sat || (w_acc[CountWidth+3:CountWidth] != 4'd0);
    assign w_large   = !r_sat && (r_cnt > i_threshold);
    assign w_digit_first_large = 1'b0;

    always_comb begin
        n_ph    = r_ph;
        n_cnt   = r_cnt;
        n_sat   = r_sat;
        n_first = r_first;
        n_found = r_found;
        if (i_item.cls == CLS_OPEN) begin
            n_ph    = PH_OPEN;
            n_cnt   = '0;
            n_sat   = 1'b0;
            n_first = w_digit_first_large;
        end else begin
            unique case (r_ph)
                PH_OPEN: begin
                    if (i_item.cls == CLS_DIGIT) begin
                        n_cnt = {{(CountWidth-4){1'b0}}, i_item.digit};
                        n_sat = 1'b0;
                        n_ph  = PH_NUM1;
                    end else if (i_item.cls != CLS_SPACE) begin
                        n_ph = PH_IDLE;
                    end
                end
                PH_NUM1: begin
                    unique case (i_item.cls)
                        CLS_DIGIT: begin
                            n_cnt = w_acc[CountWidth-1:0];
                            n_sat = w_acc_sat;
                        end
                        CLS_CLOSE: begin
                            n_found = r_found || w_large;
                            n_ph    = PH_IDLE;
                        end
                        CLS_COMMA: begin
                            n_first = w_large;
                            n_ph    = PH_COMMA;
                        end
                        CLS_SPACE: begin
                            n_first = w_large;
                            n_ph    = PH_AFTER1;
                        end
                        default: n_ph = PH_IDLE;
                    endcase
                end
                PH_AFTER1: begin
                    unique case (i_item.cls)
                        CLS_CLOSE: begin
                            n_found = r_found || r_first;
                            n_ph    = PH_IDLE;
                        end
                        CLS_COMMA: n_ph = PH_COMMA;
                        CLS_SPACE: n_ph = PH_AFTER1;
                        default:   n_ph = PH_IDLE;
                    endcase
                end
                PH_COMMA: begin
                    unique case (i_item.cls)
                        CLS_CLOSE: begin
                            n_found = r_found || r_first;
                            n_ph    = PH_IDLE;
                        end
                        CLS_DIGIT: begin
                            n_cnt = {{(CountWidth-4){1'b0}}, i_item.digit};
                            n_sat = 1'b0;
                            n_ph  = PH_NUM2;
                        end
                        CLS_SPACE: n_ph = PH_COMMA;
                        default:   n_ph = PH_IDLE;
                    endcase
                end
                PH_NUM2: begin
                    unique case (i_item.cls)
                        CLS_DIGIT: begin
                            n_cnt = w_acc[CountWidth-1:0];
                            n_sat = w_acc_sat;
                        end
                        CLS_CLOSE: begin
                            n_found = r_found || r_first || w_large;
                            n_ph    = PH_IDLE;
                        end
                        CLS_SPACE: n_ph = PH_AFTER2;
                        default:   n_ph = PH_IDLE;
                    endcase
                end
                PH_AFTER2: begin
                    unique case (i_item.cls)
                        CLS_CLOSE: begin
                            n_found = r_found || r_first || w_large;
                            n_ph    = PH_IDLE;
                        end
                        CLS_SPACE: n_ph = PH_AFTER2;
                        default:   n_ph = PH_IDLE;
                    endcase
                end
                default: n_ph = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph        <= PH_IDLE;
            r_cnt       <= '0;
            r_sat       <= 1'b0;
            r_first     <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_item.last) begin
                    r_ph    <= PH_IDLE;
                    r_cnt   <= '0;
                    r_sat   <= 1'b0;
                    r_first <= 1'b0;
                    r_found <= 1'b0;
                end else begin
                    r_ph    <= n_ph;
                    r_cnt   <= n_cnt;
                    r_sat   <= n_sat;
                    r_first <= n_first;
                    r_found <= n_found;
                end
            end
            if (o_pop && i_item.last) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.last) begin
            r_out_flag <= n_found;
        end
    end

endmodule

### sv/regex_repeat_count_screen.sv
// Repeat-count screen for regular-expression text, one byte per transfer.
// A string that holds a {N}, {N,} or {N,M} quantifier whose count exceeds
// the threshold without overflowing the count is flagged; one result transfer follows the byte with tlast.
// The block takes one byte every clock cycle while its queue is not full. The
// last byte of a string passes through the queue and, once the back end pops
// it, sets the registered m_axis_tvalid. The rate is
// set by the back-end state machine, which folds one byte per cycle
// into a 31-bit count (one multiply-by-ten add). A two-entry queue lets the
// front keep accepting while a result waits. Threshold writes are accepted in
// every cycle and must only occur while no string is in flight.
// Depends on rrcs_pkg, rrcs_front, rrcs_queue, rrcs_back.
module regex_repeat_count_screen import rrcs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] text_byte
    input  logic                  s_axis_tlast,   // end_of_text
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // [0] expensive, [7:1] zero
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CountWidth-1:0] i_cfg_data      // count_threshold
);

    logic [CountWidth-1:0] r_threshold;
    t_item                 w_front_item;
    t_item                 w_q_item;
    logic                  w_q_full;
    logic                  w_q_valid;
    logic                  w_push;
    logic                  w_pop;
    logic                  w_res_flag;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !w_q_full;
    assign w_push        = s_axis_tvalid && !w_q_full;
    assign m_axis_tdata  = {7'd0, w_res_flag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= ThresholdReset;
        end else if (i_cfg_valid) begin
            r_threshold <= i_cfg_data;
        end
    end

    rrcs_front u_front (
        .i_byte (s_axis_tdata),
        .i_last (s_axis_tlast),
        .o_item (w_front_item)
    );

    rrcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    rrcs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_threshold (r_threshold),
        .i_valid     (w_q_valid),
        .i_item      (w_q_item),
        .o_pop       (w_pop),
        .o_res_valid (m_axis_tvalid),
        .o_res_flag  (w_res_flag),
        .i_res_ready (m_axis_tready)
    );

endmodule

### sv/rrcs_checker.sv
// Port-level checks for the repeat-count screen, bound to the top level.
// Depends on regex_repeat_count_screen.
module rrcs_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  s_axis_tlast,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [7:0]            m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
        else $error("result padding not zero");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid && !(s_axis_tvalid && s_axis_tready && s_axis_tlast)
        ##1 !(s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !$rose(m_axis_tvalid)
        || $past(m_axis_tvalid, 1) || $past(s_axis_tvalid && s_axis_tready, 3))
        else $error("result without a last byte");

endmodule

bind regex_repeat_count_screen rrcs_checker u_rrcs_checker (.*);
